[rtl/sdspi_pkg.sv]
// Shared types, constants and codes of the SD card SPI-mode host sequencer.
package sdspi_pkg;

  // Block geometry
  localparam int BLOCK_BYTES = 512;
  localparam int BUF_AW      = $clog2(BLOCK_BYTES);
  localparam int CNT_W       = BUF_AW + 1;

  // Field widths
  localparam int OP_W    = 3;
  localparam int CMD_W   = 6;
  localparam int ARG_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int RETRY_W = 20;
  localparam int RLIM_W  = 8;
  localparam int CFG_W   = 20;
  localparam int CIDX_W  = 1;
  localparam int CODE_W  = 2;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_RAW   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_XCHG  = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_RESP_LIMIT = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_BUSY_LIMIT = 1'b1;

  // Result codes
  localparam logic [CODE_W-1:0] RES_OK       = 2'd0;
  localparam logic [CODE_W-1:0] RES_R1_ERR   = 2'd1;
  localparam logic [CODE_W-1:0] RES_TIMEOUT  = 2'd2;
  localparam logic [CODE_W-1:0] RES_REJECTED = 2'd3;

  // Job kinds
  localparam logic [1:0] JOB_RAW   = 2'd0;
  localparam logic [1:0] JOB_READ  = 2'd1;
  localparam logic [1:0] JOB_WRITE = 2'd2;

  // Command numbers
  localparam logic [CMD_W-1:0] CMD_IF_COND  = 6'd8;
  localparam logic [CMD_W-1:0] CMD_RD_SINGLE = 6'd17;
  localparam logic [CMD_W-1:0] CMD_RD_MULTI  = 6'd18;
  localparam logic [CMD_W-1:0] CMD_WR_SINGLE = 6'd24;
  localparam logic [CMD_W-1:0] CMD_WR_MULTI  = 6'd25;
  localparam logic [CMD_W-1:0] CMD_ER_START  = 6'd32;
  localparam logic [CMD_W-1:0] CMD_ER_END    = 6'd33;
  localparam logic [CMD_W-1:0] CMD_READ_OCR  = 6'd58;

  // Link bytes
  localparam logic [BYTE_W-1:0] CMD_START  = 8'h40;
  localparam logic [BYTE_W-1:0] CRC_CMD8   = 8'h87;
  localparam logic [BYTE_W-1:0] CRC_OTHER  = 8'h95;
  localparam logic [BYTE_W-1:0] DATA_TOKEN = 8'hFE;
  localparam logic [BYTE_W-1:0] IDLE_BYTE  = 8'hFF;
  localparam logic [4:0]        DRESP_MASK = 5'h1F;
  localparam logic [4:0]        DRESP_OK   = 5'h05;
  localparam logic [RETRY_W-1:0] RETRY_MAX = 20'hFFFFF;
  localparam int                ADDR_SHIFT = 9;

  // One input request
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CMD_W-1:0]  cmd_index;
    logic [ARG_W-1:0]  cmd_arg;
    logic [BYTE_W-1:0] rx_byte;
    logic [BUF_AW-1:0] buf_index;
    logic [BYTE_W-1:0] buf_data;
  } in_item_t;

  // One result
  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              chip_select;
    logic              rd_valid;
    logic [BUF_AW-1:0] rd_index;
    logic [BYTE_W-1:0] rd_data;
    logic              done_res;
    logic [CODE_W-1:0] result_code;
    logic [BYTE_W-1:0] response_byte;
    logic              high_capacity;
    logic              busy_res;
  } out_item_t;

  // Block buffer access from the sequencer
  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [BUF_AW-1:0] raddr;
  } buf_req_t;

endpackage

[rtl/sdspi_in_if.sv]
// Request channel interface of the SD card SPI-mode host.
interface sdspi_in_if;
  import sdspi_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CMD_W-1:0]  cmd_index;
  logic [ARG_W-1:0]  cmd_arg;
  logic [BYTE_W-1:0] rx_byte;
  logic [BUF_AW-1:0] buf_index;
  logic [BYTE_W-1:0] buf_data;

  modport source (output valid, opcode, cmd_index, cmd_arg, rx_byte, buf_index, buf_data,
                  input ready);
  modport sink (input valid, opcode, cmd_index, cmd_arg, rx_byte, buf_index, buf_data,
                output ready);
endinterface

[rtl/sdspi_out_if.sv]
// Result channel interface of the SD card SPI-mode host.
interface sdspi_out_if;
  import sdspi_pkg::*;

  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              chip_select;
  logic              rd_valid;
  logic [BUF_AW-1:0] rd_index;
  logic [BYTE_W-1:0] rd_data;
  logic              done_res;
  logic [CODE_W-1:0] result_code;
  logic [BYTE_W-1:0] response_byte;
  logic              high_capacity;
  logic              busy_res;

  modport source (output valid, tx_valid, tx_byte, chip_select, rd_valid, rd_index, rd_data,
                  done_res, result_code, response_byte, high_capacity, busy_res,
                  input ready);
  modport sink (input valid, tx_valid, tx_byte, chip_select, rd_valid, rd_index, rd_data,
                done_res, result_code, response_byte, high_capacity, busy_res,
                output ready);
endinterface

[rtl/sdspi_buf.sv]
// Block buffer: one write port, one registered read port with write-first bypass.
module sdspi_buf (
  input  logic                               clk,
  input  sdspi_pkg::buf_req_t                req,
  output logic [sdspi_pkg::BYTE_W-1:0]       rd_data
);
  import sdspi_pkg::*;

  logic [BYTE_W-1:0] mem [BLOCK_BYTES];
  logic [BYTE_W-1:0] rd_data_r;

  // Write the entry, read the addressed one, forward a same-cycle write
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      if (req.we && (req.waddr == req.raddr)) begin
        rd_data_r <= req.wdata;
      end else begin
        rd_data_r <= mem[req.raddr];
      end
    end
  end

  assign rd_data = rd_data_r;
endmodule

[rtl/sdspi_ctrl.sv]
// Byte-level sequencer: job state, poll counters, configuration and result register.
module sdspi_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sdspi_pkg::in_item_t               in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sdspi_pkg::out_item_t              out_item,
  output logic                              use_buf,
  output sdspi_pkg::buf_req_t               buf_req,
  input  logic                              cfg_we,
  input  logic [sdspi_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [sdspi_pkg::CFG_W-1:0]       cfg_wdata
);
  import sdspi_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_CMD, PH_RESP, PH_OCR, PH_CEXTRA, PH_TOKEN, PH_RDATA, PH_RCRC,
    PH_REXTRA, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP, PH_BUSY1, PH_GAP, PH_BUSY2
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [1:0]         job_r, job_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [ARG_W-1:0]   arg_r, arg_nxt;
  logic [BYTE_W-1:0]  resp_r, resp_nxt;
  logic               hc_r, hc_nxt;
  logic [RLIM_W-1:0]  resp_limit_r;
  logic [CFG_W-1:0]   busy_limit_r;
  logic               out_valid_r;
  out_item_t          out_r, res_nxt;
  logic               use_buf_r, use_buf_nxt;

  logic               accept;
  logic [RETRY_W-1:0] retry_inc;
  logic               resp_fail, busy_fail;
  logic [CMD_W-1:0]   start_cmd;
  logic [CNT_W-1:0]   cnt_inc;
  logic               active;
  logic [BYTE_W-1:0]  rx;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign rx       = in_item.rx_byte;

  // Saturating poll count and its timeout checks
  assign retry_inc = (retry_r < RETRY_MAX) ? retry_r + 1'b1 : retry_r;
  assign resp_fail = retry_inc >= {{(RETRY_W-RLIM_W){1'b0}}, resp_limit_r};
  assign busy_fail = retry_inc >= busy_limit_r;
  assign cnt_inc   = cnt_r + 1'b1;

  // Advance the job by one request
  always_comb begin
    phase_nxt = phase_r;
    job_nxt   = job_r;
    cnt_nxt   = cnt_r;
    retry_nxt = retry_r;
    cmd_nxt   = cmd_r;
    arg_nxt   = arg_r;
    resp_nxt  = resp_r;
    hc_nxt    = hc_r;
    res_nxt   = '0;

    case (in_item.opcode)
      OP_READ:  start_cmd = CMD_RD_SINGLE;
      OP_WRITE: start_cmd = CMD_WR_SINGLE;
      default:  start_cmd = in_item.cmd_index;
    endcase

    if (in_item.opcode == OP_LOAD) begin
      // buffer write only
    end else if (phase_r == PH_IDLE && in_item.opcode <= OP_WRITE) begin
      job_nxt   = in_item.opcode[1:0];
      cmd_nxt   = start_cmd;
      arg_nxt   = in_item.cmd_arg;
      if (!hc_r && (start_cmd inside {CMD_RD_SINGLE, CMD_RD_MULTI, CMD_WR_SINGLE,
                                      CMD_WR_MULTI, CMD_ER_START, CMD_ER_END})) begin
        arg_nxt = {in_item.cmd_arg[ARG_W-ADDR_SHIFT-1:0], {ADDR_SHIFT{1'b0}}};
      end
      phase_nxt = PH_CMD;
      cnt_nxt   = '0;
      retry_nxt = '0;
    end else if (phase_r != PH_IDLE && in_item.opcode == OP_XCHG) begin
      case (phase_r)
        PH_CMD: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CNT_W'(6)) begin
            phase_nxt = PH_RESP;
            cnt_nxt   = '0;
            retry_nxt = '0;
          end
        end
        PH_RESP: begin
          if (rx == IDLE_BYTE) begin
            retry_nxt = retry_inc;
            if (resp_fail) begin
              resp_nxt  = IDLE_BYTE;
              phase_nxt = PH_CEXTRA;
            end
          end else begin
            resp_nxt = rx;
            if (rx == '0 && cmd_r == CMD_READ_OCR) begin
              phase_nxt = PH_OCR;
              cnt_nxt   = '0;
            end else begin
              phase_nxt = PH_CEXTRA;
            end
          end
        end
        PH_OCR: begin
          if (cnt_r == '0) hc_nxt = rx[6];
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CNT_W'(4)) begin
            phase_nxt = PH_CEXTRA;
            cnt_nxt   = '0;
          end
        end
        PH_CEXTRA: begin
          if (job_r == JOB_RAW || resp_r != '0) begin
            res_nxt.done_res = 1'b1;
            if (resp_r == IDLE_BYTE)  res_nxt.result_code = RES_TIMEOUT;
            else if (resp_r == '0)    res_nxt.result_code = RES_OK;
            else                      res_nxt.result_code = RES_R1_ERR;
            phase_nxt = PH_IDLE;
          end else if (job_r == JOB_READ) begin
            phase_nxt = PH_TOKEN;
            retry_nxt = '0;
          end else begin
            phase_nxt = PH_WTOKEN;
          end
        end
        PH_TOKEN: begin
          if (rx == DATA_TOKEN) begin
            phase_nxt = PH_RDATA;
            cnt_nxt   = '0;
          end else begin
            retry_nxt = retry_inc;
            if (busy_fail) begin
              res_nxt.done_res    = 1'b1;
              res_nxt.result_code = RES_TIMEOUT;
              phase_nxt           = PH_IDLE;
            end
          end
        end
        PH_RDATA: begin
          res_nxt.rd_valid = 1'b1;
          res_nxt.rd_index = cnt_r[BUF_AW-1:0];
          res_nxt.rd_data  = rx;
          cnt_nxt          = cnt_inc;
          if (cnt_inc >= CNT_W'(BLOCK_BYTES)) begin
            phase_nxt = PH_RCRC;
            cnt_nxt   = '0;
          end
        end
        PH_RCRC, PH_WCRC: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CNT_W'(2)) begin
            phase_nxt = (phase_r == PH_RCRC) ? PH_REXTRA : PH_WRESP;
            cnt_nxt   = '0;
          end
        end
        PH_REXTRA: begin
          res_nxt.done_res    = 1'b1;
          res_nxt.result_code = RES_OK;
          phase_nxt           = PH_IDLE;
        end
        PH_WTOKEN: begin
          phase_nxt = PH_WDATA;
          cnt_nxt   = '0;
        end
        PH_WDATA: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CNT_W'(BLOCK_BYTES)) begin
            phase_nxt = PH_WCRC;
            cnt_nxt   = '0;
          end
        end
        PH_WRESP: begin
          resp_nxt = rx;
          if ((rx[4:0] & DRESP_MASK) != DRESP_OK) begin
            res_nxt.done_res    = 1'b1;
            res_nxt.result_code = RES_REJECTED;
            phase_nxt           = PH_IDLE;
          end else begin
            phase_nxt = PH_BUSY1;
            retry_nxt = '0;
          end
        end
        PH_GAP: begin
          phase_nxt = PH_BUSY2;
        end
        PH_BUSY1, PH_BUSY2: begin
          if (rx != '0) begin
            if (phase_r == PH_BUSY1) begin
              phase_nxt = PH_GAP;
            end else begin
              res_nxt.done_res    = 1'b1;
              res_nxt.result_code = RES_OK;
              phase_nxt           = PH_IDLE;
            end
          end else begin
            retry_nxt = retry_inc;
            if (busy_fail) begin
              res_nxt.done_res    = 1'b1;
              res_nxt.result_code = RES_TIMEOUT;
              phase_nxt           = PH_IDLE;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // Form the pending exchange from the new state
    active                = phase_nxt != PH_IDLE;
    use_buf_nxt           = 1'b0;
    res_nxt.tx_valid      = active;
    res_nxt.busy_res      = active;
    res_nxt.chip_select   = active && (phase_nxt != PH_GAP);
    res_nxt.response_byte = resp_nxt;
    res_nxt.high_capacity = hc_nxt;
    case (phase_nxt)
      PH_IDLE: res_nxt.tx_byte = '0;
      PH_CMD: begin
        case (cnt_nxt)
          CNT_W'(0): res_nxt.tx_byte = CMD_START | {2'b00, cmd_nxt};
          CNT_W'(1): res_nxt.tx_byte = arg_nxt[31:24];
          CNT_W'(2): res_nxt.tx_byte = arg_nxt[23:16];
          CNT_W'(3): res_nxt.tx_byte = arg_nxt[15:8];
          CNT_W'(4): res_nxt.tx_byte = arg_nxt[7:0];
          default:   res_nxt.tx_byte = (cmd_nxt == CMD_IF_COND) ? CRC_CMD8 : CRC_OTHER;
        endcase
      end
      PH_WTOKEN: res_nxt.tx_byte = DATA_TOKEN;
      PH_WDATA: begin
        res_nxt.tx_byte = '0;
        use_buf_nxt     = 1'b1;
      end
      default: res_nxt.tx_byte = IDLE_BYTE;
    endcase
  end

  // Buffer port: loads, read-data capture, next write byte
  always_comb begin
    buf_req.we    = 1'b0;
    buf_req.waddr = in_item.buf_index;
    buf_req.wdata = in_item.buf_data;
    if (accept && in_item.opcode == OP_LOAD) begin
      buf_req.we = 1'b1;
    end else if (accept && in_item.opcode == OP_XCHG && phase_r == PH_RDATA) begin
      buf_req.we    = 1'b1;
      buf_req.waddr = cnt_r[BUF_AW-1:0];
      buf_req.wdata = rx;
    end
    buf_req.re    = accept && use_buf_nxt;
    buf_req.raddr = cnt_nxt[BUF_AW-1:0];
  end

  // Hold state, configuration and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      job_r        <= JOB_RAW;
      cnt_r        <= '0;
      retry_r      <= '0;
      cmd_r        <= '0;
      arg_r        <= '0;
      resp_r       <= IDLE_BYTE;
      hc_r         <= 1'b0;
      resp_limit_r <= RLIM_W'(32);
      busy_limit_r <= CFG_W'(65536);
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RESP_LIMIT: resp_limit_r <= cfg_wdata[RLIM_W-1:0];
          CFG_BUSY_LIMIT: busy_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        job_r       <= job_nxt;
        cnt_r       <= cnt_nxt;
        retry_r     <= retry_nxt;
        cmd_r       <= cmd_nxt;
        arg_r       <= arg_nxt;
        resp_r      <= resp_nxt;
        hc_r        <= hc_nxt;
        out_r       <= res_nxt;
        use_buf_r   <= use_buf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign use_buf   = use_buf_r;

`ifndef SYNTHESIS
  a_start_job: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_IDLE && (in_item.opcode == OP_RAW ||
     in_item.opcode == OP_READ || in_item.opcode == OP_WRITE))
    |=> (phase_r == PH_CMD && cnt_r == '0))
    else $error("job request did not start the command phase");
  a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.busy_res == (phase_r != PH_IDLE)))
    else $error("busy flag disagrees with sequencer phase");
  a_done_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res) |-> !out_r.busy_res)
    else $error("job reported done while still busy");
  a_buf_byte_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (use_buf_r == (phase_r == PH_WDATA)))
    else $error("buffer byte selected outside the write data phase");
`endif
endmodule

[rtl/sd_spi_block_transaction_engine.sv]
// Top level of the SD card SPI-mode host sequencer.
// Each accepted request (a job start, a finished SPI byte exchange or a buffer load) yields
// exactly one result in the next cycle, and a new request is taken every cycle while the
// result register is free or being drained; the rate is one request per clock, set by the
// single result register and the registered read port of the 512-byte block buffer. The
// result tells the SPI driver which byte to shift next and whether to select the card, and
// flags delivered read bytes and job completion. Buffer entries hold no defined value until
// loaded or filled by a block read, so sending an unwritten entry yields an arbitrary byte.
// The user must write configuration registers only while no job is running (not enforced).
module sd_spi_block_transaction_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  sdspi_in_if.sink                      in_chan,
  sdspi_out_if.source                   out_chan,
  input  logic                          cfg_we,
  input  logic [sdspi_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [sdspi_pkg::CFG_W-1:0]   cfg_wdata
);
  import sdspi_pkg::*;

  in_item_t          in_item;
  out_item_t         res;
  buf_req_t          buf_req;
  logic              use_buf;
  logic [BYTE_W-1:0] buf_rd_data;

  // Gather the request fields
  assign in_item.opcode    = in_chan.opcode;
  assign in_item.cmd_index = in_chan.cmd_index;
  assign in_item.cmd_arg   = in_chan.cmd_arg;
  assign in_item.rx_byte   = in_chan.rx_byte;
  assign in_item.buf_index = in_chan.buf_index;
  assign in_item.buf_data  = in_chan.buf_data;

  sdspi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_item   (in_item),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (res),
    .use_buf   (use_buf),
    .buf_req   (buf_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sdspi_buf u_buf (
    .clk     (clk),
    .req     (buf_req),
    .rd_data (buf_rd_data)
  );

  // Drive the result, taking the write byte from the buffer in the data phase
  assign out_chan.tx_valid      = res.tx_valid;
  assign out_chan.tx_byte       = use_buf ? buf_rd_data : res.tx_byte;
  assign out_chan.chip_select   = res.chip_select;
  assign out_chan.rd_valid      = res.rd_valid;
  assign out_chan.rd_index      = res.rd_index;
  assign out_chan.rd_data       = res.rd_data;
  assign out_chan.done_res      = res.done_res;
  assign out_chan.result_code   = res.result_code;
  assign out_chan.response_byte = res.response_byte;
  assign out_chan.high_capacity = res.high_capacity;
  assign out_chan.busy_res      = res.busy_res;
endmodule
